@@ hdl/sddw_pkg.sv @@
// ----------------------------------------------------------------------------
// sddw_pkg
// Shared constants, types and helper functions for the signed decimal digit
// writer.
// ----------------------------------------------------------------------------
`default_nettype none

package sddw_pkg;

   localparam int VALUE_W = 28;
   localparam int ADDR_W  = 4;
   localparam int CODE_W  = 4;

   localparam int MAX_DIGITS_DEFAULT = 8;

   localparam logic [CODE_W-1:0] CODE_BLANK = 4'hF;
   localparam logic [CODE_W-1:0] CODE_MINUS = 4'hA;

   localparam logic [3:0] DIGIT_COUNT_RESET = 4'd8;

   // Reciprocal of ten: q = (n * RECIP_TEN) >> RECIP_SHIFT is exact for n < 2^32
   localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
   localparam int          RECIP_SHIFT = 35;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic longint pow10(input int n);
      longint p;
      p = 1;
      for (int i = 0; i < n; i++) begin
         p = p * 10;
      end
      return p;
   endfunction

   // Bits needed for a magnitude of up to 10^digits - 1
   function automatic int mag_width(input int digits);
      return $clog2(pow10(digits));
   endfunction

   // Queue entry: sign flag, clear count, magnitude
   function automatic int job_width(input int digits);
      return 1 + 4 + mag_width(digits);
   endfunction

endpackage

`default_nettype wire

@@ hdl/sddw_front.sv @@
// ----------------------------------------------------------------------------
// sddw_front
// Holds the configuration register, takes in numbers, saturates them and
// pushes a classified job (sign, clear count, magnitude) into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sddw_front import sddw_pkg::*; #(
   parameter int MAX_DIGITS = MAX_DIGITS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output      logic                          busy,
   input  wire logic [VALUE_W-1:0]            req_value,
   input  wire logic                          csr_valid,
   output      logic                          csr_ready,
   input  wire logic [3:0]                    csr_digit_count,
   input  wire queue_status_type              queue_status,
   output      logic                          push,
   output      logic [job_width(MAX_DIGITS)-1:0] push_job
);

   localparam int MAG_W = mag_width(MAX_DIGITS);

   localparam logic [VALUE_W:0] POS_MAX = (VALUE_W + 1)'(pow10(MAX_DIGITS) - 1);
   localparam logic [VALUE_W:0] NEG_MAX = (VALUE_W + 1)'(pow10(MAX_DIGITS - 1) - 1);

   typedef struct packed {
      logic             neg;
      logic [3:0]       clr;
      logic [MAG_W-1:0] mag;
   } job_type;

   logic               item_valid_ff, item_valid_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [3:0]         digit_count_ff, digit_count_in;

   logic               accept;
   logic               is_neg;
   logic [VALUE_W:0]   val_ext;
   logic [VALUE_W:0]   abs_val;
   logic [VALUE_W:0]   bound;
   logic [VALUE_W:0]   mag_sat;
   logic [3:0]         clr;
   job_type            job;

   assign csr_ready = 1'b1;
   assign busy      = item_valid_ff;
   assign accept    = start & ~item_valid_ff;
   assign push      = item_valid_ff & ~queue_status.full;

   always_comb begin
      item_valid_in  = accept | (item_valid_ff & ~push);
      value_in       = accept ? req_value : value_ff;
      digit_count_in = (csr_valid && csr_ready) ? csr_digit_count : digit_count_ff;
   end

   // Saturate to what the display can show; keep room for the minus sign
   always_comb begin
      is_neg  = value_ff[VALUE_W-1];
      val_ext = {value_ff[VALUE_W-1], value_ff};
      abs_val = is_neg ? (~val_ext + 1'b1) : val_ext;
      bound   = is_neg ? NEG_MAX : POS_MAX;
      mag_sat = (abs_val > bound) ? bound : abs_val;
   end

   always_comb begin
      if (digit_count_ff == 4'd0) begin
         clr = 4'd1;
      end else if (digit_count_ff > 4'(MAX_DIGITS)) begin
         clr = 4'(MAX_DIGITS);
      end else begin
         clr = digit_count_ff;
      end
   end

   always_comb begin
      job.mag  = mag_sat[MAG_W-1:0];
      // a magnitude saturated to zero shows as a plain zero
      job.neg  = is_neg & (mag_sat != '0);
      job.clr  = clr;
      push_job = job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff  <= 1'b0;
         digit_count_ff <= DIGIT_COUNT_RESET;
      end else begin
         item_valid_ff  <= item_valid_in;
         digit_count_ff <= digit_count_in;
      end
      value_ff <= value_in;
   end

endmodule

`default_nettype wire

@@ hdl/sddw_queue.sv @@
// ----------------------------------------------------------------------------
// sddw_queue
// Short FIFO of classified jobs between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sddw_queue import sddw_pkg::*; #(
   parameter int WIDTH = job_width(MAX_DIGITS_DEFAULT)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output      logic [WIDTH-1:0] head_data,
   output      queue_status_type status
);

   logic [WIDTH-1:0]  entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push, do_pop;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign status.full  = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_data    = entry_ff[rd_ptr_ff];

   assign do_push = push & ~status.full;
   assign do_pop  = pop & ~status.empty;

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ hdl/sddw_back.sv @@
// ----------------------------------------------------------------------------
// sddw_back
// Write sequencer: blanks the positions in use, then peels off one decimal
// digit per cycle by reciprocal multiplication, then the minus sign.
// ----------------------------------------------------------------------------
`default_nettype none

module sddw_back import sddw_pkg::*; #(
   parameter int MAX_DIGITS = MAX_DIGITS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire queue_status_type                 queue_status,
   input  wire logic [job_width(MAX_DIGITS)-1:0] head_job,
   output      logic                             pop,
   output      logic                             rsp_strobe,
   output      logic [ADDR_W-1:0]                rsp_reg_addr,
   output      logic [CODE_W-1:0]                rsp_digit_code,
   output      logic                             rsp_last
);

   localparam int MAG_W = mag_width(MAX_DIGITS);

   typedef struct packed {
      logic             neg;
      logic [3:0]       clr;
      logic [MAG_W-1:0] mag;
   } job_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BLANK,
      ST_DIGIT,
      ST_SIGN
   } state_type;

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  pos_ff, pos_in;
   logic [MAG_W-1:0]   mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic               strobe_ff, strobe_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [CODE_W-1:0]  code_ff, code_in;
   logic               last_ff, last_in;

   job_type            job;
   logic [63:0]        product;
   logic [MAG_W-1:0]   quo;
   logic [MAG_W+3:0]   quo_x10;
   logic [CODE_W-1:0]  rem;

   assign job = job_type'(head_job);

   // divide by ten: multiply by the reciprocal, then recover the remainder
   always_comb begin
      product = 64'({{(32 - MAG_W){1'b0}}, mag_ff}) * 64'(RECIP_TEN);
      quo     = product[RECIP_SHIFT +: MAG_W];
      quo_x10 = ((MAG_W + 4)'(quo) << 3) + ((MAG_W + 4)'(quo) << 1);
      rem     = CODE_W'((MAG_W + 4)'(mag_ff) - quo_x10);
   end

   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      strobe_in = 1'b0;
      addr_in   = addr_ff;
      code_in   = code_ff;
      last_in   = 1'b0;
      pop       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!queue_status.empty) begin
               pop      = 1'b1;
               pos_in   = job.clr;
               mag_in   = job.mag;
               neg_in   = job.neg;
               state_in = ST_BLANK;
            end
         end
         ST_BLANK: begin
            strobe_in = 1'b1;
            addr_in   = pos_ff;
            code_in   = CODE_BLANK;
            if (pos_ff == ADDR_W'(1)) begin
               state_in = ST_DIGIT;
            end else begin
               pos_in = pos_ff - 1'b1;
            end
         end
         ST_DIGIT: begin
            strobe_in = 1'b1;
            addr_in   = pos_ff;
            code_in   = rem;
            mag_in    = quo;
            pos_in    = pos_ff + 1'b1;
            if (quo == '0) begin
               if (neg_ff) begin
                  state_in = ST_SIGN;
               end else begin
                  last_in  = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SIGN: begin
            strobe_in = 1'b1;
            addr_in   = pos_ff;
            code_in   = CODE_MINUS;
            last_in   = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
         last_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         last_ff   <= last_in;
      end
      pos_ff  <= pos_in;
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      addr_ff <= addr_in;
      code_ff <= code_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_reg_addr   = addr_ff;
   assign rsp_digit_code = code_ff;
   assign rsp_last       = last_ff;

endmodule

`default_nettype wire

@@ hdl/signed_decimal_digit_writer_top.sv @@
// ----------------------------------------------------------------------------
// signed_decimal_digit_writer_top
// Turns a signed number into the digit-register writes of an eight-digit
// code-B seven-segment driver: blanks, digits, then minus sign.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+------------------------------
//  request   | in        | start, busy             | req_value
//  response  | out       | rsp_strobe (no stall)   | rsp_reg_addr, rsp_digit_code,
//            |           |                         | rsp_last
//  csr       | in        | csr_valid, csr_ready    | csr_digit_count
//
//  A number is written as clr blanked positions, then its d digits, then
//  a minus sign if it is negative; the write sequencer emits one register
//  write per cycle while it works through a number.
//  The front end takes a new number in the cycle after it hands the previous
//  one to the two-entry job queue; busy is high while it holds a number not yet queued.
//  Synchronous reset empties the queue and sets digit_count to 8.
//  Writes are shown for one cycle each; the receiver cannot stall them.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_decimal_digit_writer_top import sddw_pkg::*; #(
   parameter int MAX_DIGITS = MAX_DIGITS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output      logic               busy,
   input  wire logic [VALUE_W-1:0] req_value,
   output      logic               rsp_strobe,
   output      logic [ADDR_W-1:0]  rsp_reg_addr,
   output      logic [CODE_W-1:0]  rsp_digit_code,
   output      logic               rsp_last,
   input  wire logic               csr_valid,
   output      logic               csr_ready,
   input  wire logic [3:0]         csr_digit_count
);

   localparam int JOB_W = job_width(MAX_DIGITS);

   queue_status_type   queue_status;
   logic               push;
   logic               pop;
   logic [JOB_W-1:0]   push_job;
   logic [JOB_W-1:0]   head_job;

   sddw_front #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_value       (req_value),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_digit_count (csr_digit_count),
      .queue_status    (queue_status),
      .push            (push),
      .push_job        (push_job)
   );

   sddw_queue #(
      .WIDTH (JOB_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_job),
      .pop       (pop),
      .head_data (head_job),
      .status    (queue_status)
   );

   sddw_back #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .queue_status   (queue_status),
      .head_job       (head_job),
      .pop            (pop),
      .rsp_strobe     (rsp_strobe),
      .rsp_reg_addr   (rsp_reg_addr),
      .rsp_digit_code (rsp_digit_code),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire

@@ hdl/sddw_checker.sv @@
// ----------------------------------------------------------------------------
// sddw_checker
// Port-level checks on the write stream of the digit writer.
// ----------------------------------------------------------------------------
`default_nettype none

module sddw_checker import sddw_pkg::*; #(
   parameter int MAX_DIGITS = MAX_DIGITS_DEFAULT
) (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_strobe,
   input wire logic [ADDR_W-1:0]  rsp_reg_addr,
   input wire logic [CODE_W-1:0]  rsp_digit_code,
   input wire logic               rsp_last
);

   // no transfer right after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("response strobe right after reset");

   // addresses stay on the display
   a_addr_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_reg_addr != '0) && (rsp_reg_addr <= ADDR_W'(MAX_DIGITS)))
      else $error("register address out of range");

   // a blank never ends a burst
   a_blank_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_digit_code == CODE_BLANK) |-> !rsp_last)
      else $error("blank write marked last");

   // the minus sign always ends a burst
   a_minus_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_digit_code == CODE_MINUS) |-> rsp_last)
      else $error("minus write not marked last");

   // after blanking the rightmost position the first digit lands there next
   a_first_digit: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_digit_code == CODE_BLANK && rsp_reg_addr == ADDR_W'(1))
      |=> (rsp_strobe && rsp_reg_addr == ADDR_W'(1) && rsp_digit_code <= CODE_W'(9)))
      else $error("first digit does not follow the blanking");

endmodule

bind signed_decimal_digit_writer_top sddw_checker #(
   .MAX_DIGITS (MAX_DIGITS)
) u_sddw_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_strobe      (rsp_strobe),
   .rsp_reg_addr    (rsp_reg_addr),
   .rsp_digit_code  (rsp_digit_code),
   .rsp_last        (rsp_last)
);

`default_nettype wire
